### design/pbs_pkg.sv
package pbs_pkg;

    localparam int DEFAULT_STORE_BYTES = 1024;

    localparam int CURSOR_W = 13;
    localparam int COUNT_W  = 14;
    localparam int POS_W    = 16;
    localparam int TOTAL_W  = 16;
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    localparam int CURSOR_MAX = 8191;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 14'd16383;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 16'hffff;

    localparam logic [3:0] FIELD_WIDTH_RESET = 4'd3;
    localparam logic [APB_ADDR_W-1:0] REG_FIELD_WIDTH = 2'd0;

    typedef enum logic [1:0] {
        CMD_APPEND     = 2'd0,
        CMD_READ_INDEX = 2'd1,
        CMD_READ_NEXT  = 2'd2,
        CMD_SET_CURSOR = 2'd3
    } pbs_cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } pbs_state_t;

    function automatic logic [3:0] pbs_eff_width(input logic [3:0] w);
        logic [3:0] r;
        if (w == 4'd0) begin
            r = 4'd1;
        end else if (w > 4'd8) begin
            r = 4'd8;
        end else begin
            r = w;
        end
        return r;
    endfunction

    function automatic logic [7:0] pbs_mask(input logic [3:0] w);
        logic [3:0] n;
        n = 4'd8 - w;
        return 8'hff >> n;
    endfunction

    function automatic logic [4:0] pbs_shift(input logic [2:0] off, input logic [3:0] w);
        return 5'd16 - {1'b0, w} - {2'b00, off};
    endfunction

    function automatic logic [7:0] pbs_extract(
        input logic [7:0] hi,
        input logic [7:0] lo,
        input logic [2:0] off,
        input logic [3:0] w
    );
        logic [15:0] win;
        win = {hi, lo} >> pbs_shift(off, w);
        return win[7:0] & pbs_mask(w);
    endfunction

    function automatic logic [15:0] pbs_insert(
        input logic [7:0] hi,
        input logic [2:0] off,
        input logic [3:0] w,
        input logic [7:0] val
    );
        logic [7:0]  keep;
        logic [15:0] field;
        keep  = hi & ~(8'hff >> off);
        field = {8'h00, val & pbs_mask(w)} << pbs_shift(off, w);
        return {keep, 8'h00} | field;
    endfunction

endpackage

### design/pbs_ram.sv
module pbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/pbs_cfg.sv
module pbs_cfg
    import pbs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [3:0]            field_width
);

    logic [3:0] field_width_reg;
    logic       wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr == REG_FIELD_WIDTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_width_reg <= FIELD_WIDTH_RESET;
        end else if (wr_hit) begin
            field_width_reg <= pwdata[3:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == REG_FIELD_WIDTH) begin
            prdata = {28'h0, field_width_reg};
        end
    end

    assign field_width = field_width_reg;

endmodule

### design/pbs_core.sv
module pbs_core
    import pbs_pkg::*;
#(
    parameter int STORE_BYTES = DEFAULT_STORE_BYTES
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [3:0]          field_width,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_cmd,
    input  logic [7:0]          s_field_value,
    input  logic [12:0]         s_element_index,
    input  logic [12:0]         s_bit_position,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_read_value,
    output logic [TOTAL_W-1:0]  m_total_bits,
    output logic [CURSOR_W-1:0] m_cursor_now,
    output logic                m_range_error
);

    localparam int ROWS = (STORE_BYTES + 1) / 2;
    localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SEQ_LIMIT = (STORE_BYTES * 8 < CURSOR_MAX) ? STORE_BYTES * 8 : CURSOR_MAX;
    localparam logic [16:0] BYTES_L = 17'(STORE_BYTES);
    localparam logic [31:0] BITS_L = 32'(STORE_BYTES * 8);
    localparam logic [13:0] SEQ_LIMIT_L = 14'(SEQ_LIMIT);
    localparam logic [AW-1:0] LAST_ROW = AW'(ROWS - 1);

    pbs_state_t state_reg, state_next;
    logic [AW-1:0] clr_row_reg;

    pbs_cmd_t            cmd_reg;
    logic [7:0]          fval_reg;
    logic [12:0]         bpos_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [CURSOR_W-1:0] cursor_reg, cursor_next;
    logic [COUNT_W-1:0]  count_reg, count_next;

    logic                m_valid_reg;
    logic [7:0]          m_read_value_reg;
    logic [TOTAL_W-1:0]  m_total_bits_reg;
    logic [CURSOR_W-1:0] m_cursor_now_reg;
    logic                m_range_error_reg;

    logic [3:0]       w;
    logic [POS_W-1:0] idx_prod, pos_in, pos_sel;
    logic [12:0]      b;
    logic [13:0]      b1, even_idx, odd_idx;
    logic [AW-1:0]    even_row, odd_row;
    logic             hi_ok, lo_ok;
    logic [7:0]       even_rdata, odd_rdata, hi_rd, lo_rd;
    logic [13:0]      seq_end;
    logic [16:0]      idx_end;
    logic             seq_err, idx_err, set_err, err;
    logic [7:0]       rd_val;
    logic [15:0]      new_win;
    logic             go, accept, clearing, wr_field, we_hi, we_lo;
    logic             even_we, odd_we;
    logic [AW-1:0]    even_waddr, odd_waddr;
    logic [7:0]       even_wdata, odd_wdata;
    logic [17:0]      total_full;
    logic [TOTAL_W-1:0] total_sat;

    assign w        = pbs_eff_width(field_width);
    assign clearing = (state_reg == ST_CLEAR);
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign go       = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);

    assign idx_prod = {3'b000, s_element_index} * {12'h000, w};
    assign pos_in   = (pbs_cmd_t'(s_cmd) == CMD_READ_INDEX) ? idx_prod : {3'b000, cursor_reg};
    assign pos_sel  = (state_reg == ST_IDLE) ? pos_in : pos_reg;

    assign b        = pos_sel[15:3];
    assign b1       = {1'b0, b} + 14'd1;
    assign even_idx = b[0] ? b1 : {1'b0, b};
    assign odd_idx  = b[0] ? {1'b0, b} : b1;
    assign even_row = AW'(even_idx >> 1);
    assign odd_row  = AW'(odd_idx >> 1);
    assign hi_ok    = {4'h0, b} < BYTES_L;
    assign lo_ok    = {3'b000, b1} < BYTES_L;

    assign hi_rd = hi_ok ? (b[0] ? odd_rdata : even_rdata) : 8'h00;
    assign lo_rd = lo_ok ? (b[0] ? even_rdata : odd_rdata) : 8'h00;

    assign seq_end = {1'b0, cursor_reg} + {10'h000, w};
    assign seq_err = seq_end > SEQ_LIMIT_L;
    assign idx_end = {1'b0, pos_reg} + {13'h0000, w};
    assign idx_err = {15'h0000, idx_end} > BITS_L;
    assign set_err = {1'b0, bpos_reg} > SEQ_LIMIT_L;

    assign new_win = pbs_insert(hi_rd, pos_reg[2:0], w, fval_reg);

    always_comb begin
        err         = 1'b0;
        rd_val      = 8'h00;
        cursor_next = cursor_reg;
        count_next  = count_reg;
        wr_field    = 1'b0;
        unique case (cmd_reg)
            CMD_APPEND: begin
                err = seq_err;
                if (!seq_err) begin
                    wr_field    = 1'b1;
                    cursor_next = seq_end[CURSOR_W-1:0];
                    if (count_reg != COUNT_MAX) begin
                        count_next = count_reg + 14'd1;
                    end
                end
            end
            CMD_READ_INDEX: begin
                err = idx_err;
                if (!idx_err) begin
                    rd_val = pbs_extract(hi_rd, lo_rd, pos_reg[2:0], w);
                end
            end
            CMD_READ_NEXT: begin
                err = seq_err;
                if (!seq_err) begin
                    rd_val      = pbs_extract(hi_rd, lo_rd, pos_reg[2:0], w);
                    cursor_next = seq_end[CURSOR_W-1:0];
                end
            end
            CMD_SET_CURSOR: begin
                err = set_err;
                if (!set_err) begin
                    cursor_next = bpos_reg;
                end
            end
            default: begin
                err = 1'b0;
            end
        endcase
    end

    assign total_full = {4'h0, count_next} * {14'h0000, w};
    assign total_sat  = (total_full > {2'b00, TOTAL_MAX}) ? TOTAL_MAX : total_full[TOTAL_W-1:0];

    assign we_hi = go && wr_field && hi_ok;
    assign we_lo = go && wr_field && lo_ok;

    always_comb begin
        if (clearing) begin
            even_we    = 1'b1;
            odd_we     = 1'b1;
            even_waddr = clr_row_reg;
            odd_waddr  = clr_row_reg;
            even_wdata = 8'h00;
            odd_wdata  = 8'h00;
        end else begin
            even_we    = b[0] ? we_lo : we_hi;
            odd_we     = b[0] ? we_hi : we_lo;
            even_waddr = even_row;
            odd_waddr  = odd_row;
            even_wdata = b[0] ? new_win[7:0] : new_win[15:8];
            odd_wdata  = b[0] ? new_win[15:8] : new_win[7:0];
        end
    end

    pbs_ram #(
        .WIDTH(8),
        .DEPTH(ROWS)
    ) u_even_bank (
        .aclk (aclk),
        .we   (even_we),
        .waddr(even_waddr),
        .wdata(even_wdata),
        .re   (s_ready),
        .raddr(even_row),
        .rdata(even_rdata)
    );

    pbs_ram #(
        .WIDTH(8),
        .DEPTH(ROWS)
    ) u_odd_bank (
        .aclk (aclk),
        .we   (odd_we),
        .waddr(odd_waddr),
        .wdata(odd_wdata),
        .re   (s_ready),
        .raddr(odd_row),
        .rdata(odd_rdata)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_row_reg == LAST_ROW) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (go) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_row_reg <= '0;
            cursor_reg  <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (clearing) begin
                clr_row_reg <= clr_row_reg + AW'(1);
            end
            if (go) begin
                cursor_reg  <= cursor_next;
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg  <= pbs_cmd_t'(s_cmd);
            fval_reg <= s_field_value;
            bpos_reg <= s_bit_position;
            pos_reg  <= pos_in;
        end
        if (go) begin
            m_read_value_reg  <= rd_val;
            m_total_bits_reg  <= total_sat;
            m_cursor_now_reg  <= cursor_next;
            m_range_error_reg <= err;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_read_value  = m_read_value_reg;
    assign m_total_bits  = m_total_bits_reg;
    assign m_cursor_now  = m_cursor_now_reg;
    assign m_range_error = m_range_error_reg;

endmodule

### design/packed_bitfield_store.sv
// Byte store of fixed-width fields packed MSB-first, with a bit cursor for appends and
// sequential reads and a saturating append count. The bytes live in two banks, even and
// odd, so both bytes of the two-byte window around a field are read together. The cycle a
// beat is accepted reads both banks; the execute state then extracts or inserts the
// field, writes the window back and loads the result register. The execute state
// waits while an earlier result has not been taken. After reset the banks are cleared
// one row per cycle, ceil(STORE_BYTES/2) rows, with s_ready low; configuration writes
// are taken during that time.
module packed_bitfield_store
    import pbs_pkg::*;
#(
    parameter int STORE_BYTES = DEFAULT_STORE_BYTES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_cmd,
    input  logic [7:0]            s_field_value,
    input  logic [12:0]           s_element_index,
    input  logic [12:0]           s_bit_position,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_read_value,
    output logic [TOTAL_W-1:0]    m_total_bits,
    output logic [CURSOR_W-1:0]   m_cursor_now,
    output logic                  m_range_error
);

    logic [3:0] field_width;

    pbs_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .field_width(field_width)
    );

    pbs_core #(
        .STORE_BYTES(STORE_BYTES)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .field_width    (field_width),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_field_value  (s_field_value),
        .s_element_index(s_element_index),
        .s_bit_position (s_bit_position),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_value   (m_read_value),
        .m_total_bits   (m_total_bits),
        .m_cursor_now   (m_cursor_now),
        .m_range_error  (m_range_error)
    );

endmodule

### verif/packed_bitfield_store_test.sv
`timescale 1ns / 1ps

module packed_bitfield_store_test;
    import pbs_pkg::*;

    localparam int STORE_BYTES = DEFAULT_STORE_BYTES;
    localparam int STORE_BITS  = STORE_BYTES * 8;
    localparam int SEQ_LIMIT   = (STORE_BITS < CURSOR_MAX) ? STORE_BITS : CURSOR_MAX;
    localparam int QUIET_LIMIT = 4000;

    typedef struct {
        pbs_cmd_t    cmd;
        logic [7:0]  fval;
        logic [12:0] eidx;
        logic [12:0] bpos;
    } access_t;

    typedef struct packed {
        logic [7:0]          read_value;
        logic [TOTAL_W-1:0]  total_bits;
        logic [CURSOR_W-1:0] cursor_now;
        logic                range_error;
    } outcome_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    pbs_cmd_t              s_cmd = CMD_APPEND;
    logic [7:0]            s_field_value = '0;
    logic [12:0]           s_element_index = '0;
    logic [12:0]           s_bit_position = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [7:0]            m_read_value;
    logic [TOTAL_W-1:0]    m_total_bits;
    logic [CURSOR_W-1:0]   m_cursor_now;
    logic                  m_range_error;

    packed_bitfield_store #(.STORE_BYTES(STORE_BYTES)) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_field_value   (s_field_value),
        .s_element_index (s_element_index),
        .s_bit_position  (s_bit_position),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_value    (m_read_value),
        .m_total_bits    (m_total_bits),
        .m_cursor_now    (m_cursor_now),
        .m_range_error   (m_range_error)
    );

    always #6 aclk = ~aclk;

    // Shadow copy of the store, cursor, append count and width register.
    logic [7:0] store_img [STORE_BYTES];
    int         cursor_img = 0;
    int         count_img = 0;
    logic [3:0] width_img = FIELD_WIDTH_RESET;

    access_t    pending_accesses [$];
    outcome_t   expected_outcomes [$];
    int         queued = 0;
    int         beats_in = 0;
    int         results_seen = 0;
    int         range_errors = 0;
    int         failures = 0;
    int         quiet_cycles = 0;
    logic       beat_in = 1'b0;
    bit         idling = 1'b1;
    int         in_gap = 0;
    int         out_gap = 0;

    function automatic int eff_width(input logic [3:0] r);
        if (r == 4'd0) begin
            return 1;
        end else if (r > 4'd8) begin
            return 8;
        end
        return int'(r);
    endfunction

    function automatic int byte_at(input int idx);
        return (idx < STORE_BYTES) ? int'(store_img[idx]) : 0;
    endfunction

    function automatic int field_at(input int pos, input int w);
        int win;
        win = (byte_at(pos >> 3) << 8) | byte_at((pos >> 3) + 1);
        return (win >> (16 - w - (pos & 7))) & ((1 << w) - 1);
    endfunction

    function automatic outcome_t apply_access(input access_t a);
        int w;
        int pos;
        int b;
        int off;
        int win;
        int total;
        outcome_t o;
        w = eff_width(width_img);
        o = '0;
        case (a.cmd)
            CMD_APPEND: begin
                if (cursor_img + w > SEQ_LIMIT) begin
                    o.range_error = 1'b1;
                end else begin
                    b   = cursor_img >> 3;
                    off = cursor_img & 7;
                    win = (byte_at(b) << 8) & ~(16'hffff >> off) & 16'hffff;
                    win = win | ((int'(a.fval) & ((1 << w) - 1)) << (16 - w - off));
                    if (b < STORE_BYTES) store_img[b] = win[15:8];
                    if (b + 1 < STORE_BYTES) store_img[b + 1] = win[7:0];
                    cursor_img += w;
                    if (count_img < int'(COUNT_MAX)) count_img++;
                end
            end
            CMD_READ_INDEX: begin
                pos = int'(a.eidx) * w;
                if (pos + w > STORE_BITS) begin
                    o.range_error = 1'b1;
                end else begin
                    o.read_value = 8'(field_at(pos, w));
                end
            end
            CMD_READ_NEXT: begin
                if (cursor_img + w > SEQ_LIMIT) begin
                    o.range_error = 1'b1;
                end else begin
                    o.read_value = 8'(field_at(cursor_img, w));
                    cursor_img += w;
                end
            end
            default: begin
                if (int'(a.bpos) > SEQ_LIMIT) begin
                    o.range_error = 1'b1;
                end else begin
                    cursor_img = int'(a.bpos);
                end
            end
        endcase
        total = count_img * w;
        if (total > int'(TOTAL_MAX)) total = int'(TOTAL_MAX);
        o.total_bits = TOTAL_W'(total);
        o.cursor_now = CURSOR_W'(cursor_img);
        return o;
    endfunction

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            failures++;
        end
    endfunction

    always @(posedge aclk) begin : monitor
        access_t  acc;
        outcome_t want;
        beat_in <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            acc.cmd  = s_cmd;
            acc.fval = s_field_value;
            acc.eidx = s_element_index;
            acc.bpos = s_bit_position;
            want = apply_access(acc);
            if (want.range_error) range_errors++;
            expected_outcomes.push_back(want);
            beats_in++;
        end
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_outcomes.size() == 0) begin
                $display("%0t: result with nothing expected, read %0d total %0d cursor %0d err %0d",
                         $time, m_read_value, m_total_bits, m_cursor_now, m_range_error);
                failures++;
            end else begin
                want = expected_outcomes.pop_front();
                compare_field("read_value", 16'(want.read_value), 16'(m_read_value));
                compare_field("total_bits", want.total_bits, m_total_bits);
                compare_field("cursor_now", 16'(want.cursor_now), 16'(m_cursor_now));
                compare_field("range_error", 16'(want.range_error), 16'(m_range_error));
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(negedge aclk) begin : driver
        access_t a;
        if (aresetn && (!s_valid || beat_in)) begin
            if (in_gap > 0) begin
                in_gap--;
                s_valid <= 1'b0;
            end else if (idling && $urandom_range(0, 9) == 0) begin
                in_gap = $urandom_range(0, 9);
                s_valid <= 1'b0;
            end else if (pending_accesses.size() > 0) begin
                a = pending_accesses.pop_front();
                s_valid         <= 1'b1;
                s_cmd           <= a.cmd;
                s_field_value   <= a.fval;
                s_element_index <= a.eidx;
                s_bit_position  <= a.bpos;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin : result_taker
        if (out_gap > 0) begin
            out_gap--;
            m_ready <= 1'b0;
        end else if (idling && $urandom_range(0, 9) == 0) begin
            out_gap = $urandom_range(0, 9);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic write_field_width(input logic [3:0] w);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= REG_FIELD_WIDTH;
        pwdata  <= {28'd0, w};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        width_img = w;
    endtask

    task automatic push_access(input pbs_cmd_t c, input int f, input int e, input int p);
        access_t a;
        a.cmd  = c;
        a.fval = 8'(f);
        a.eidx = 13'(e);
        a.bpos = 13'(p);
        pending_accesses.push_back(a);
        queued++;
    endtask

    task automatic wait_idle();
        do begin
            @(negedge aclk);
        end while (beats_in != queued || s_valid || expected_outcomes.size() != 0);
    endtask

    // Mostly append runs read back by cursor and by index, plus end-of-store probes and noise.
    task automatic queue_random_phase(input logic [3:0] reg_w, input int n);
        int w;
        int start;
        int r;
        int k;
        int p;
        int len;
        bit aligned;
        w = eff_width(reg_w);
        start = queued;
        while (queued - start < n) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                len = $urandom_range(1, 12);
                if ($urandom_range(0, 3) == 0) begin
                    k = $urandom_range(0, SEQ_LIMIT / w - 1);
                end else begin
                    k = $urandom_range(0, 40);
                end
                aligned = ($urandom_range(0, 1) == 1);
                p = aligned ? k * w : k * w + $urandom_range(0, w - 1);
                push_access(CMD_SET_CURSOR, $urandom, $urandom, p);
                for (int j = 0; j < len; j++) push_access(CMD_APPEND, $urandom, $urandom, $urandom);
                push_access(CMD_SET_CURSOR, $urandom, $urandom, p);
                for (int j = 0; j < len; j++) begin
                    push_access(CMD_READ_NEXT, $urandom, $urandom, $urandom);
                end
                if (aligned) begin
                    for (int j = 0; j < len; j++) begin
                        push_access(CMD_READ_INDEX, $urandom, k + j, $urandom);
                    end
                end
            end else if (r < 70) begin
                push_access(CMD_SET_CURSOR, $urandom, $urandom,
                            SEQ_LIMIT - $urandom_range(0, 3 * w));
                len = $urandom_range(1, 4);
                for (int j = 0; j < len; j++) begin
                    push_access($urandom_range(0, 1) ? CMD_APPEND : CMD_READ_NEXT,
                                $urandom, $urandom, $urandom);
                end
                push_access(CMD_READ_INDEX, $urandom,
                            STORE_BITS / w - 1 + $urandom_range(0, 1), $urandom);
            end else begin
                push_access(pbs_cmd_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
            end
        end
    endtask

    initial begin : stimulus
        logic [3:0] width_plan [11];
        width_plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd5, 4'd2, 4'd7, 4'd4, 4'd6, 4'd9, 4'd3};
        foreach (store_img[i]) store_img[i] = 8'h00;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        write_field_width(4'd3);

        push_access(CMD_READ_NEXT, 8'h00, 13'd0, 13'd0);
        push_access(CMD_SET_CURSOR, 8'h00, 13'd0, 13'd0);
        push_access(CMD_APPEND, 8'hff, 13'd0, 13'd0);
        push_access(CMD_APPEND, 8'h00, 13'd0, 13'd0);
        push_access(CMD_APPEND, 8'h05, 13'd0, 13'd0);
        push_access(CMD_READ_INDEX, 8'h00, 13'd0, 13'd0);
        push_access(CMD_READ_INDEX, 8'h00, 13'd2, 13'd0);
        push_access(CMD_READ_INDEX, 8'h00, 13'h1fff, 13'd0);
        push_access(CMD_SET_CURSOR, 8'h00, 13'd0, 13'd3);
        push_access(CMD_READ_NEXT, 8'h00, 13'd0, 13'd0);
        push_access(CMD_SET_CURSOR, 8'h00, 13'd0, 13'd8191);
        push_access(CMD_APPEND, 8'h07, 13'd0, 13'd0);
        push_access(CMD_READ_NEXT, 8'h00, 13'd0, 13'd0);
        push_access(CMD_SET_CURSOR, 8'h00, 13'd0, 13'd8188);
        push_access(CMD_APPEND, 8'hff, 13'd0, 13'd0);
        push_access(CMD_SET_CURSOR, 8'h00, 13'd0, 13'd8184);
        push_access(CMD_READ_NEXT, 8'h00, 13'd0, 13'd0);
        push_access(CMD_READ_INDEX, 8'h00, 13'd2729, 13'd0);
        push_access(CMD_READ_INDEX, 8'h00, 13'd2730, 13'd0);
        wait_idle();
        write_field_width(4'd8);
        push_access(CMD_SET_CURSOR, 8'h00, 13'd0, 13'd8184);
        push_access(CMD_APPEND, 8'h81, 13'd0, 13'd0);
        push_access(CMD_READ_INDEX, 8'h00, 13'd1023, 13'd0);
        push_access(CMD_READ_INDEX, 8'h00, 13'd1024, 13'd0);
        push_access(CMD_SET_CURSOR, 8'h00, 13'd0, 13'd4);
        push_access(CMD_APPEND, 8'hc3, 13'd0, 13'd0);
        push_access(CMD_READ_INDEX, 8'h00, 13'd0, 13'd0);
        wait_idle();

        // The last phase and the checks after it run without idle cycles.
        foreach (width_plan[i]) begin
            write_field_width(width_plan[i]);
            idling = (i == $size(width_plan) - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            queue_random_phase(width_plan[i], 170);
            wait_idle();
        end

        idling = 1'b0;
        write_field_width(4'd1);
        push_access(CMD_READ_NEXT, $urandom, $urandom, $urandom);
        push_access(CMD_READ_INDEX, $urandom, $urandom, $urandom);
        wait_idle();
        write_field_width(4'd4);
        push_access(CMD_SET_CURSOR, $urandom, $urandom, 13'd100);
        push_access(CMD_APPEND, $urandom, $urandom, $urandom);
        push_access(CMD_READ_INDEX, $urandom, 13'd25, $urandom);
        wait_idle();
        repeat (20) @(negedge aclk);

        $display("Ran %0d accesses at field widths 0 to 15; %0d results checked, %0d range errors.",
                 beats_in, results_seen, range_errors);
        $display("Append count reached %0d, cursor ended at %0d.", count_img, cursor_img);
        if (failures == 0 && expected_outcomes.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### packed_bitfield_store.f
design/pbs_pkg.sv
design/pbs_ram.sv
design/pbs_cfg.sv
design/pbs_core.sv
design/packed_bitfield_store.sv
verif/packed_bitfield_store_test.sv
